FILE: sv/cosine_similarity_search_macros.svh
// ----------------------------------------------------------------------------
// Cosine similarity search assertion macros
// Shared concurrent assertion forms for the block's RTL.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_SEARCH_MACROS_SVH
`define COSINE_SIMILARITY_SEARCH_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CSS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("assertion failed");

// Check that a condition is followed by a consequence in the next cycle.
`define CSS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/csim_pkg.sv
// ----------------------------------------------------------------------------
// Cosine similarity search package
// Widths, status codes and the request/response types of the ratio unit.
// ----------------------------------------------------------------------------
package csim_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int ADDR_W     = $clog2(MAX_DIM);
    localparam int LEN_W      = ADDR_W + 1;
    localparam int ELEM_W     = 16;
    localparam int SQ_W       = 2 * ELEM_W;
    localparam int NORM_W     = SQ_W + LEN_W - 2;
    localparam int ACC_W      = NORM_W + 1;
    localparam int MUL_W      = ACC_W;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int RATIO_W    = 15;
    localparam int RSHIFT     = 2 * RATIO_W;
    localparam int TRIAL_W    = PROD_W + RSHIFT + 2;
    localparam int SIM_W      = 16;
    localparam int STAT_W     = 2;
    localparam int IDX_W      = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LEN   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOQRY = 2'd3;

    localparam logic CMD_QUERY = 1'b0;
    localparam logic CMD_CAND  = 1'b1;

    typedef struct packed {
        logic              start;
        logic [MUL_W-1:0]  nq;
        logic [MUL_W-1:0]  nv;
        logic [MUL_W-1:0]  mag;
    } t_ratio_req;

    typedef struct packed {
        logic               done;
        logic [RATIO_W-1:0] ratio;
    } t_ratio_rsp;

endpackage

FILE: sv/csim_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module csim_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/csim_ratio.sv
// ----------------------------------------------------------------------------
// Cosine ratio unit
// Finds the largest s below 2^15 with s^2*nq*nv <= 2^30*mag^2: two shift-add
// products, then one result bit per cycle.
// ----------------------------------------------------------------------------
module csim_ratio (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  csim_pkg::t_ratio_req i_req,
    output csim_pkg::t_ratio_rsp o_rsp
);
    import csim_pkg::*;

    localparam logic [1:0] RS_IDLE = 2'd0;
    localparam logic [1:0] RS_MUL1 = 2'd1;
    localparam logic [1:0] RS_MUL2 = 2'd2;
    localparam logic [1:0] RS_SRCH = 2'd3;

    logic [1:0]          r_state;
    logic                r_done;
    logic [5:0]          r_cnt;
    logic [PROD_W-1:0]   r_acc;
    logic [PROD_W-1:0]   r_mcand;
    logic [MUL_W-1:0]    r_mplier;
    logic [MUL_W-1:0]    r_mag;
    logic [PROD_W-1:0]   r_p;
    logic [TRIAL_W-1:0]  r_r;
    logic [TRIAL_W-1:0]  r_a;
    logic [TRIAL_W-1:0]  r_c;
    logic [TRIAL_W-1:0]  r_d;
    logic [RATIO_W-1:0]  r_s;

    logic [PROD_W-1:0]   w_acc_add;
    logic [TRIAL_W-1:0]  w_t;
    logic                w_take;

    always_comb begin
        w_acc_add = r_mplier[0] ? (r_acc + r_mcand) : r_acc;
        w_t       = r_a + r_c + r_d;
        w_take    = (w_t <= r_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                RS_IDLE: begin
                    if (i_req.start) begin
                        r_state <= RS_MUL1;
                    end
                end
                RS_MUL1: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= RS_MUL2;
                    end
                end
                RS_MUL2: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= RS_SRCH;
                    end
                end
                RS_SRCH: begin
                    if (r_cnt == 6'd0) begin
                        r_state <= RS_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= RS_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            RS_IDLE: begin
                r_acc    <= '0;
                r_mcand  <= PROD_W'(i_req.nq);
                r_mplier <= i_req.nv;
                r_mag    <= i_req.mag;
                r_cnt    <= 6'(MUL_W - 1);
            end
            RS_MUL1, RS_MUL2: begin
                r_acc    <= w_acc_add;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    if (r_state == RS_MUL1) begin
                        r_p      <= w_acc_add;
                        r_acc    <= '0;
                        r_mcand  <= PROD_W'(r_mag);
                        r_mplier <= r_mag;
                        r_cnt    <= 6'(MUL_W - 1);
                    end else begin
                        r_r   <= TRIAL_W'(w_acc_add) << RSHIFT;
                        r_a   <= '0;
                        r_c   <= '0;
                        r_d   <= TRIAL_W'(r_p) << (2 * (RATIO_W - 1));
                        r_s   <= '0;
                        r_cnt <= 6'(RATIO_W - 1);
                    end
                end
            end
            default: begin
                r_s   <= {r_s[RATIO_W-2:0], w_take};
                r_a   <= w_take ? w_t : r_a;
                r_c   <= (r_c >> 1) + (w_take ? r_d : '0);
                r_d   <= r_d >> 2;
                r_cnt <= r_cnt - 6'd1;
            end
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.ratio = r_s;

endmodule

FILE: sv/cosine_similarity_search.sv
// ----------------------------------------------------------------------------
// Cosine similarity search
// A query element is taken in the idle state. A candidate element, once a
// query is loaded, needs the query store read, then the multiply-accumulate.
// The last element of a candidate that matches a loaded query, with nonzero
// norms, starts the ratio unit (two 42-step shift-add products, then a
// 15-step bit search); an error result goes straight to output. Output is
// held in a register, so one result may wait while the next items stream in.
// tuser carries the command (0 query, 1 candidate), tlast the last flag.
// ----------------------------------------------------------------------------
`include "cosine_similarity_search_macros.svh"

module cosine_similarity_search (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [csim_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,  // [15:0] element
    input  logic                               i_s_axis_tuser,  // [0] command
    input  logic                               i_s_axis_tlast,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [15:0] similarity, [17:16] status, [33:18] candidate_index, [39:34] zero
    output logic [csim_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);
    import csim_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_FIN   = 3'd2;
    localparam logic [2:0] ST_RATIO = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]         r_state;
    logic [LEN_W-1:0]   r_qlen;
    logic [NORM_W-1:0]  r_qnorm;
    logic               r_qvalid;
    logic               r_qovf;
    logic [LEN_W-1:0]   r_pos;
    logic [ACC_W-1:0]   r_dot;
    logic [NORM_W-1:0]  r_cnorm;
    logic [IDX_W-1:0]   r_cnt;
    logic               r_bad;
    logic               r_use_q;
    logic               r_fin;
    logic signed [ELEM_W-1:0] r_e;
    logic [STAT_W-1:0]  r_status;
    logic [SIM_W-1:0]   r_sim;
    logic               r_neg;
    logic               r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;

    logic                     w_accept;
    logic signed [ELEM_W-1:0] w_in_e;
    logic signed [SQ_W-1:0]   w_in_sq;
    logic signed [SQ_W-1:0]   w_e_sq;
    logic signed [SQ_W-1:0]   w_qe;
    logic [ELEM_W-1:0]        w_rdata;
    logic                     w_we;
    logic [ADDR_W-1:0]        w_waddr;
    logic [LEN_W-1:0]         w_base_len;
    logic [ACC_W-1:0]         w_mag;
    logic [SIM_W-1:0]         w_ratio_ext;
    logic                     w_load_out;
    t_ratio_req               w_req;
    t_ratio_rsp               w_rsp;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_e          = i_s_axis_tdata[ELEM_W-1:0];
    assign w_in_sq         = w_in_e * w_in_e;
    assign w_e_sq          = r_e * r_e;
    assign w_qe            = r_use_q ? ($signed(w_rdata) * r_e) : SQ_W'(0);
    assign w_base_len      = r_qvalid ? '0 : r_qlen;
    assign w_we            = w_accept && (i_s_axis_tuser == CMD_QUERY)
                             && (w_base_len < LEN_W'(MAX_DIM));
    assign w_waddr         = w_base_len[ADDR_W-1:0];
    assign w_mag           = r_dot[ACC_W-1] ? (~r_dot + ACC_W'(1)) : r_dot;
    assign w_ratio_ext     = SIM_W'(w_rsp.ratio);
    assign w_load_out      = (r_state == ST_OUT) && (!r_ovalid || i_m_axis_tready);

    assign w_req.start = (r_state == ST_FIN) && r_qvalid && !r_qovf && !r_bad
                         && (r_pos == r_qlen) && (r_qnorm != '0) && (r_cnorm != '0);
    assign w_req.nq    = MUL_W'(r_qnorm);
    assign w_req.nv    = MUL_W'(r_cnorm);
    assign w_req.mag   = w_mag;

    csim_ram #(
        .WIDTH(ELEM_W),
        .DEPTH(MAX_DIM)
    ) u_qstore (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(i_s_axis_tdata[ELEM_W-1:0]),
        .i_raddr(r_pos[ADDR_W-1:0]),
        .o_rdata(w_rdata)
    );

    csim_ratio u_ratio (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_qlen   <= '0;
            r_qnorm  <= '0;
            r_qvalid <= 1'b0;
            r_qovf   <= 1'b0;
            r_pos    <= '0;
            r_dot    <= '0;
            r_cnorm  <= '0;
            r_cnt    <= '0;
            r_bad    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && i_s_axis_tuser == CMD_QUERY) begin
                        if (r_qvalid) begin
                            r_cnt   <= '0;
                            r_pos   <= '0;
                            r_dot   <= '0;
                            r_cnorm <= '0;
                            r_bad   <= 1'b0;
                        end
                        if (w_base_len < LEN_W'(MAX_DIM)) begin
                            r_qlen  <= w_base_len + LEN_W'(1);
                            r_qnorm <= (r_qvalid ? '0 : r_qnorm) + NORM_W'(w_in_sq);
                            r_qovf  <= r_qvalid ? 1'b0 : r_qovf;
                        end else begin
                            r_qlen  <= w_base_len;
                            r_qnorm <= r_qvalid ? '0 : r_qnorm;
                            r_qovf  <= 1'b1;
                        end
                        r_qvalid <= i_s_axis_tlast;
                    end else if (w_accept) begin
                        if (r_qvalid) begin
                            r_state <= ST_MAC;
                        end else if (i_s_axis_tlast) begin
                            r_state <= ST_FIN;
                        end
                    end
                end
                ST_MAC: begin
                    r_dot   <= r_dot + ACC_W'(w_qe);
                    r_cnorm <= r_cnorm + NORM_W'(w_e_sq);
                    if (r_pos < LEN_W'(MAX_DIM)) begin
                        r_pos <= r_pos + LEN_W'(1);
                        r_bad <= r_bad || !r_use_q;
                    end else begin
                        r_bad <= 1'b1;
                    end
                    r_state <= r_fin ? ST_FIN : ST_IDLE;
                end
                ST_FIN: begin
                    r_state <= w_req.start ? ST_RATIO : ST_OUT;
                end
                ST_RATIO: begin
                    if (w_rsp.done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (w_load_out) begin
                        r_cnt    <= r_cnt + IDX_W'(1);
                        r_pos    <= '0;
                        r_dot    <= '0;
                        r_cnorm  <= '0;
                        r_bad    <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e     <= w_in_e;
            r_fin   <= i_s_axis_tlast;
            r_use_q <= (r_pos < r_qlen);
        end
        if (r_state == ST_FIN) begin
            r_neg <= r_dot[ACC_W-1];
            r_sim <= '0;
            if (!r_qvalid) begin
                r_status <= STAT_NOQRY;
            end else if (r_qovf || r_bad || r_pos != r_qlen) begin
                r_status <= STAT_LEN;
            end else if (r_qnorm == '0 || r_cnorm == '0) begin
                r_status <= STAT_ZERO;
            end else begin
                r_status <= STAT_OK;
            end
        end
        if (r_state == ST_RATIO && w_rsp.done) begin
            r_sim <= r_neg ? (~w_ratio_ext + SIM_W'(1)) : w_ratio_ext;
        end
        if (w_load_out) begin
            r_odata <= OUT_DATA_W'({r_cnt, r_status, r_sim});
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    `CSS_ASSERT(a_qlen_range, r_qlen <= LEN_W'(MAX_DIM))
    `CSS_ASSERT(a_pos_range, r_pos <= LEN_W'(MAX_DIM))
    `CSS_ASSERT(a_start_needs_query, w_req.start |-> (r_qvalid && r_pos == r_qlen))
    `CSS_ASSERT(a_ratio_blocks_input, (r_state == ST_RATIO) |-> !o_s_axis_tready)
    `CSS_ASSERT_NEXT(a_done_to_out, r_state == ST_RATIO && w_rsp.done, r_state == ST_OUT)

endmodule
